// ----- rtl/core/sha1s_pkg.sv -----
// sha1s_pkg: shared types, constants and round functions for the SHA-1 stream core
// no dependencies; imported by sha1s_buffer, sha1s_round and sha1_hash_stream_core
package sha1s_pkg;

  typedef logic [31:0]        word_t;
  typedef logic [15:0][31:0]  block_t;
  typedef logic [4:0][31:0]   chain_t;

  // sha-1 initial chaining words, index 0 is the first word
  localparam chain_t INIT_CHAIN = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                   32'hefcdab89, 32'h67452301};

  localparam word_t K_0 = 32'h5a827999;
  localparam word_t K_1 = 32'h6ed9eba1;
  localparam word_t K_2 = 32'h8f1bbcdc;
  localparam word_t K_3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [2:0] WORD_BYTES  = 3'd4;
  localparam logic [2:0] LAST_INDEX  = 3'd4;

  // write operation applied to the block buffer
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_DATA   = 2'd1,
    WR_PAD    = 2'd2,
    WR_LENGTH = 2'd3
  } wr_mode_e;

  typedef struct packed {
    wr_mode_e   mode;
    logic [5:0] fill;
    logic [2:0] n_bytes;
  } buf_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_status_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // round function for round t
  function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                    input word_t c, input word_t d);
    if (t < 7'd20) begin
      round_f = d ^ (b & (c ^ d));
    end else if (t < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      round_f = (b & c) | (d & (b | c));
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  // round constant for round t
  function automatic word_t round_k(input logic [6:0] t);
    if (t < 7'd20) begin
      round_k = K_0;
    end else if (t < 7'd40) begin
      round_k = K_1;
    end else if (t < 7'd60) begin
      round_k = K_2;
    end else begin
      round_k = K_3;
    end
  endfunction

endpackage

// ----- rtl/core/sha1s_buffer.sv -----
// sha1s_buffer: 16-word block buffer with byte-granular data and padding writes
// depends on sha1s_pkg
module sha1s_buffer
  import sha1s_pkg::*;
(
  input  logic        clk_i,
  input  buf_ctrl_t   ctrl_i,
  input  word_t       word_i,
  input  logic [63:0] bit_len_i,
  output block_t      blk_o
);

  block_t blk_q, blk_d;

  // byte lane writes for message data and padding
  always_comb begin : wr_logic
    logic [5:0] off;
    logic [6:0] stop;
    blk_d = blk_q;
    off   = '0;
    stop  = 7'(ctrl_i.fill) + 7'(ctrl_i.n_bytes);
    unique case (ctrl_i.mode)
      WR_DATA: begin
        for (int p = 0; p < 64; p++) begin
          off = 6'(p) - ctrl_i.fill;
          if ((6'(p) >= ctrl_i.fill) && (7'(p) < stop)) begin
            blk_d[p/4][(3-(p%4))*8 +: 8] = word_i[{~off[1:0], 3'b000} +: 8];
          end
        end
      end
      WR_PAD: begin
        for (int p = 0; p < 64; p++) begin
          if (6'(p) == ctrl_i.fill) begin
            blk_d[p/4][(3-(p%4))*8 +: 8] = PAD_BYTE;
          end else if (6'(p) > ctrl_i.fill) begin
            blk_d[p/4][(3-(p%4))*8 +: 8] = 8'h00;
          end
        end
        // length fits behind the pad byte
        if (ctrl_i.fill < LEN_POS) begin
          blk_d[14] = bit_len_i[63:32];
          blk_d[15] = bit_len_i[31:0];
        end
      end
      WR_LENGTH: begin
        blk_d     = '0;
        blk_d[14] = bit_len_i[63:32];
        blk_d[15] = bit_len_i[31:0];
      end
      default: begin
        blk_d = blk_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign blk_o = blk_q;

endmodule

// ----- rtl/core/sha1s_round.sv -----
// sha1s_round: iterative sha-1 compression, one round per cycle
// depends on sha1s_pkg; message schedule kept in a 16-word shift window
module sha1s_round
  import sha1s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  chain_t      chain_i,
  input  block_t      block_i,
  output rnd_status_t status_o,
  output chain_t      work_o
);

  chain_t     work_q, work_d;
  block_t     sched_q, sched_d;
  logic [6:0] t_q, t_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  word_t      w_next, tmp;

  // schedule window holds w[t..t+15], slot 0 is the current word
  assign w_next = rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);

  // one sha-1 round: work[0..4] = a..e
  assign tmp = rotl(work_q[0], 5) + round_f(t_q, work_q[1], work_q[2], work_q[3])
             + work_q[4] + round_k(t_q) + sched_q[0];

  // round sequencing
  always_comb begin
    work_d  = work_q;
    sched_d = sched_q;
    t_d     = t_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      work_d  = chain_i;
      sched_d = block_i;
      t_d     = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      work_d  = {work_q[3], work_q[2], rotl(work_q[1], 30), work_q[0], tmp};
      sched_d = {w_next, sched_q[15:1]};
      t_d     = t_q + 7'd1;
      if (t_q == LAST_ROUND) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      t_q    <= t_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    sched_q <= sched_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign work_o        = work_q;

endmodule

// ----- rtl/core/sha1_hash_stream_core.sv -----
// sha1_hash_stream_core: sha-1 over a stream of big-endian 32-bit words
// depends on sha1s_pkg, sha1s_buffer and sha1s_round
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries data_word_i, valid_bytes_i
//   (0..4 upper bytes, values above 4 count as 4) and end_of_message_i.
//   Output channel (out_valid_o/out_ready_i) carries five digest words, index
//   0 first, last_word_o high on index 4; only the final word of a message
//   produces output.
//   Timing: the block takes one word at a time. A word that does not fill the
//   64-byte buffer passes through a transfer and a byte-packing step. A word
//   that completes a block adds a launch step, 80 rounds in the shared round
//   unit (one round per cycle), the chaining add and one more packing step
//   for the bytes left over. The final word adds one or two padded blocks,
//   each hashed the same way, then the five digest words, one per cycle while
//   the receiver is ready.
//   in_ready_o is high only while the core is idle.
//   A stalled receiver holds the core in its output phase; nothing is lost.
//   Reset loads the initial chaining words and clears the byte counts; the
//   core is ready in the first cycle after reset, and again after the fifth
//   digest word is taken, when it restarts for the next message.
module sha1_hash_stream_core
  import sha1s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ABSORB = 6'b000010,
    ST_PAD    = 6'b000100,
    ST_LAUNCH = 6'b001000,
    ST_HASH   = 6'b010000,
    ST_OUTPUT = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;
  chain_t      chain_q, chain_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] msg_q, msg_d;
  word_t       pend_word_q, pend_word_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic        last_q, last_d;
  logic        pad2_q, pad2_d;
  logic [2:0]  idx_q, idx_d;

  buf_ctrl_t   buf_ctrl;
  block_t      blk;
  rnd_status_t rnd_status;
  chain_t      work;
  logic        start;
  logic [2:0]  in_cnt;
  logic [6:0]  room;
  logic [2:0]  n_fit;
  logic [6:0]  fill_new;
  logic [63:0] bit_len;

  // clamp the byte count of a transfer
  assign in_cnt = (valid_bytes_i > WORD_BYTES) ? WORD_BYTES : valid_bytes_i;

  // bytes of the pending word that fit in the current block
  assign room     = BLOCK_BYTES - 7'(fill_q);
  assign n_fit    = (7'(pend_cnt_q) > room) ? room[2:0] : pend_cnt_q;
  assign fill_new = 7'(fill_q) + 7'(n_fit);
  assign bit_len  = {msg_q[60:0], 3'b000};

  // sequencer
  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    chain_d       = chain_q;
    fill_d        = fill_q;
    msg_d         = msg_q;
    pend_word_d   = pend_word_q;
    pend_cnt_d    = pend_cnt_q;
    last_d        = last_q;
    pad2_d        = pad2_q;
    idx_d         = idx_q;
    buf_ctrl.mode    = WR_NONE;
    buf_ctrl.fill    = fill_q;
    buf_ctrl.n_bytes = n_fit;
    start         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pend_word_d = data_word_i;
          pend_cnt_d  = in_cnt;
          last_d      = end_of_message_i;
          msg_d       = msg_q + 64'(in_cnt);
          state_d     = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        buf_ctrl.mode = WR_DATA;
        pend_cnt_d    = pend_cnt_q - n_fit;
        pend_word_d   = pend_word_q << {n_fit, 3'b000};
        if (fill_new == BLOCK_BYTES) begin
          fill_d  = '0;
          ret_d   = ST_ABSORB;
          state_d = ST_LAUNCH;
        end else begin
          fill_d  = fill_new[5:0];
          state_d = last_q ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        state_d = ST_LAUNCH;
        if (pad2_q) begin
          buf_ctrl.mode = WR_LENGTH;
          ret_d         = ST_OUTPUT;
        end else begin
          buf_ctrl.mode = WR_PAD;
          if (fill_q < LEN_POS) begin
            ret_d = ST_OUTPUT;
          end else begin
            pad2_d = 1'b1;
            ret_d  = ST_PAD;
          end
        end
      end
      ST_LAUNCH: begin
        start   = 1'b1;
        state_d = ST_HASH;
      end
      ST_HASH: begin
        if (rnd_status.done) begin
          for (int i = 0; i < 5; i++) begin
            chain_d[i] = chain_q[i] + work[i];
          end
          state_d = ret_q;
        end
      end
      ST_OUTPUT: begin
        if (out_ready_i) begin
          if (idx_q == LAST_INDEX) begin
            chain_d = INIT_CHAIN;
            fill_d  = '0;
            msg_d   = '0;
            pad2_d  = 1'b0;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ret_q      <= ST_IDLE;
      chain_q    <= INIT_CHAIN;
      fill_q     <= '0;
      msg_q      <= '0;
      pend_cnt_q <= '0;
      last_q     <= 1'b0;
      pad2_q     <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      chain_q    <= chain_d;
      fill_q     <= fill_d;
      msg_q      <= msg_d;
      pend_cnt_q <= pend_cnt_d;
      last_q     <= last_d;
      pad2_q     <= pad2_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_word_q <= pend_word_d;
  end

  sha1s_buffer u_buffer (
    .clk_i     (clk_i),
    .ctrl_i    (buf_ctrl),
    .word_i    (pend_word_q),
    .bit_len_i (bit_len),
    .blk_o     (blk)
  );

  sha1s_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .chain_i  (chain_q),
    .block_i  (blk),
    .status_o (rnd_status),
    .work_o   (work)
  );

  // port outputs
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUTPUT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LAST_INDEX);

endmodule
